// File: design/assert_macros.svh
// Assertion macros shared by the battery monitor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BVM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BVM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/bvm_pkg.sv
// Shared widths, constants and the sequencer state type of the battery monitor.
`timescale 1ns / 1ps

package bvm_pkg;

   localparam int RawW  = 12;
   localparam int VrefW = 11;
   localparam int VoltW = 13;
   localparam int PctW  = 7;

   localparam logic [VrefW-1:0] VrefReset = 11'd1100;

   // raw * vref * 66 / 40950 reduces exactly to raw * vref * 11 / 6825.
   localparam int ScaleMul   = 11;
   localparam int ScaleDiv   = 6825;
   localparam int ProdW      = 27;
   localparam int ScaleShift = 27;
   localparam int RecipW     = 15;
   localparam int ScaleRecip = (2 ** ScaleShift) / ScaleDiv;
   localparam int QuotW      = 15;

   localparam logic [VoltW-1:0] VoltMax = 13'd8191;
   localparam logic [VoltW-1:0] FullMv  = 13'd4200;
   localparam logic [VoltW-1:0] EmptyMv = 13'd3000;
   localparam logic [PctW-1:0]  PctFull = 7'd100;
   localparam logic [PctW-1:0]  PctNone = 7'd0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RECIP,
      ST_CORR,
      ST_UPD,
      ST_AVG,
      ST_FIX,
      ST_OUT
   } bvm_state_type;

endpackage

// File: design/bvm_if.sv
// Request and response channel interfaces of the battery monitor.
`timescale 1ns / 1ps

interface bvm_req_if import bvm_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [RawW-1:0] raw_sample;

   modport source (output valid, output raw_sample, input ready);
   modport sink   (input valid, input raw_sample, output ready);
endinterface

interface bvm_rsp_if import bvm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [VoltW-1:0] voltage_mv;
   logic [VoltW-1:0] average_mv;
   logic [PctW-1:0]  charge_percent;
   logic             drop_warning;

   modport source (output valid, output voltage_mv, output average_mv,
                   output charge_percent, output drop_warning, input ready);
   modport sink   (input valid, input voltage_mv, input average_mv,
                   input charge_percent, input drop_warning, output ready);
endinterface

// File: design/battery_voltage_monitor_top.sv
// Battery voltage monitor: ADC scaling, moving-average ring, charge and drop flags.
// Sequencer: each accepted request steps through ST_RECIP, ST_CORR, ST_UPD, ST_AVG, ST_FIX and
// ST_OUT, which holds while the output is stalled; a new request is taken only in ST_IDLE,
// after the scaling reciprocal, the ring read-modify-write and the average reciprocal are done.
// Reset (synchronous, active high) empties the window through per-entry valid bits at once,
// so no clearing pass is needed; vref_ff returns to 1100 mV.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module battery_voltage_monitor_top import bvm_pkg::*; #(
   parameter int WINDOW_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [VrefW-1:0] csr_wr_data,
   bvm_req_if.sink          req_ch,
   bvm_rsp_if.source        rsp_ch
);

   // Window geometry. The sum must hold WINDOW_DEPTH full-scale voltages.
   localparam int PtrW     = $clog2(WINDOW_DEPTH);
   localparam int SumW     = $clog2(WINDOW_DEPTH * 8191 + 1);
   localparam int AvgRecip = (2 ** SumW) / WINDOW_DEPTH;

   localparam logic [PtrW-1:0]     PtrLast   = PtrW'(WINDOW_DEPTH - 1);
   localparam logic [SumW-1:0]     AvgRecipV = SumW'(AvgRecip);
   localparam logic [SumW-1:0]     DepthV    = SumW'(WINDOW_DEPTH);
   localparam logic [ProdW-1:0]    ScaleDivV = ProdW'(ScaleDiv);
   localparam logic [ProdW-1:0]    ScaleRemMax = ProdW'(2 * ScaleDiv);
   localparam logic [RecipW-1:0]   ScaleRecipV = RecipW'(ScaleRecip);

   // Control state.
   bvm_state_type            state_ff, state_in;
   logic [VrefW-1:0]         vref_ff;
   logic [PtrW-1:0]          wptr_ff, wptr_in;
   logic [SumW-1:0]          sum_ff, sum_in;
   logic [WINDOW_DEPTH-1:0]  valid_ff;
   logic                     rsp_valid_ff;

   // Datapath registers.
   logic [ProdW-1:0]   prod_ff, prod_in;
   logic [QuotW-1:0]   quot_est_ff, quot_est_in;
   logic [VoltW-1:0]   volt_ff, volt_in;
   logic [SumW-1:0]    avg_est_ff, avg_est_in;
   logic [VoltW-1:0]   avg_ff, avg_in;
   logic [VoltW-1:0]   rd_ff;
   logic               old_valid_ff;
   logic [VoltW-1:0]   rsp_volt_ff, rsp_avg_ff;
   logic [PctW-1:0]    rsp_pct_ff, pct_in;
   logic               rsp_drop_ff, drop_in;

   // The sample ring itself.
   logic [VoltW-1:0]   ring_mem [WINDOW_DEPTH];

   logic               req_fire;
   logic               out_free;
   logic               out_load;
   logic [RawW+3:0]    raw_x11;
   logic [ProdW+RecipW-1:0] scale_recip_prod;
   logic [ProdW-1:0]   scale_back;
   logic [ProdW-1:0]   scale_rem;
   logic [QuotW-1:0]   quot;
   logic [VoltW-1:0]   old_sample;
   logic [2*SumW-1:0]  avg_recip_prod;
   logic [SumW-1:0]    avg_back;
   logic [SumW-1:0]    avg_rem;
   logic [SumW-1:0]    avg_fix;
   logic [VoltW-1:0]   charge_span;
   logic [VoltW-3:0]   charge_quarter;
   logic [VoltW+5:0]   charge_third;
   logic [VoltW+3:0]   volt_x10;
   logic [VoltW+3:0]   avg_x9;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign out_load = (state_ff == ST_OUT) && out_free;

   assign req_ch.ready          = (state_ff == ST_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.voltage_mv     = rsp_volt_ff;
   assign rsp_ch.average_mv     = rsp_avg_ff;
   assign rsp_ch.charge_percent = rsp_pct_ff;
   assign rsp_ch.drop_warning   = rsp_drop_ff;

   // Scaling, first step: raw * 11 by shift-and-add, then one multiply by vref.
   always_comb begin
      raw_x11 = ((RawW+4)'(req_ch.raw_sample) << 3) + ((RawW+4)'(req_ch.raw_sample) << 1)
              + (RawW+4)'(req_ch.raw_sample);
      prod_in = ProdW'(raw_x11) * ProdW'(vref_ff);
   end

   // Scaling, second step: estimate the quotient by 6825 with a reciprocal multiply.
   // The estimate is the true quotient or one short of it.
   always_comb begin
      scale_recip_prod = (ProdW+RecipW)'(prod_ff) * (ProdW+RecipW)'(ScaleRecipV);
      quot_est_in      = scale_recip_prod[ProdW+RecipW-1:ScaleShift];
   end

   // Scaling, third step: one compare-and-correct step, then saturate to 13 bits.
   always_comb begin
      scale_back = ProdW'(quot_est_ff) * ScaleDivV;
      scale_rem  = prod_ff - scale_back;
      quot       = quot_est_ff + QuotW'(scale_rem >= ScaleDivV);
      volt_in    = (quot > QuotW'(VoltMax)) ? VoltMax : quot[VoltW-1:0];
   end

   // Ring update: entries never written since reset count as zero.
   always_comb begin
      old_sample = old_valid_ff ? rd_ff : '0;
      sum_in     = sum_ff - SumW'(old_sample) + SumW'(volt_ff);
      wptr_in    = (wptr_ff == PtrLast) ? '0 : wptr_ff + PtrW'(1);
   end

   // Window average: reciprocal estimate, then one correction in the following cycle.
   always_comb begin
      avg_recip_prod = (2*SumW)'(sum_ff) * (2*SumW)'(AvgRecipV);
      avg_est_in     = avg_recip_prod[2*SumW-1:SumW];
      avg_back       = avg_est_ff * DepthV;
      avg_rem        = sum_ff - avg_back;
      avg_fix        = avg_est_ff + SumW'(avg_rem >= DepthV);
      avg_in         = avg_fix[VoltW-1:0];
   end

   // Charge percentage: (avg - 3000) * 100 / 1200 equals (avg - 3000) / 12, taken as
   // a quarter and then a third by multiplying with 171 / 512, exact below 1200.
   // The drop flag compares ten times the voltage with nine times the average exactly.
   always_comb begin
      charge_span    = avg_ff - EmptyMv;
      charge_quarter = charge_span[VoltW-1:2];
      charge_third   = (VoltW+6)'(charge_quarter) * (VoltW+6)'(171);
      if (avg_ff >= FullMv) begin
         pct_in = PctFull;
      end else if (avg_ff <= EmptyMv) begin
         pct_in = PctNone;
      end else begin
         pct_in = charge_third[PctW+8:9];
      end
      volt_x10 = ((VoltW+4)'(volt_ff) << 3) + ((VoltW+4)'(volt_ff) << 1);
      avg_x9   = ((VoltW+4)'(avg_ff) << 3) + (VoltW+4)'(avg_ff);
      drop_in  = (volt_x10 < avg_x9);
   end

   // Sequencer: one request at a time, one step per cycle except in ST_OUT, which waits for the output to be free.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_RECIP;
            end
         end
         ST_RECIP: state_in = ST_CORR;
         ST_CORR:  state_in = ST_UPD;
         ST_UPD:   state_in = ST_AVG;
         ST_AVG:   state_in = ST_FIX;
         ST_FIX:   state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers that reset clears.
   always_ff @(posedge clock) begin
      if (reset) begin
         vref_ff      <= VrefReset;
         wptr_ff      <= '0;
         sum_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            vref_ff <= csr_wr_data;
         end
         if (state_ff == ST_UPD) begin
            wptr_ff           <= wptr_in;
            sum_ff            <= sum_in;
            valid_ff[wptr_ff] <= 1'b1;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Ring memory: the old entry is read as the request is accepted and the new voltage
   // is written back in ST_UPD, before the next request can be accepted.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_ff        <= ring_mem[wptr_ff];
         old_valid_ff <= valid_ff[wptr_ff];
      end
      if (state_ff == ST_UPD) begin
         ring_mem[wptr_ff] <= volt_ff;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         prod_ff <= prod_in;
      end
      if (state_ff == ST_RECIP) begin
         quot_est_ff <= quot_est_in;
      end
      if (state_ff == ST_CORR) begin
         volt_ff <= volt_in;
      end
      if (state_ff == ST_AVG) begin
         avg_est_ff <= avg_est_in;
      end
      if (state_ff == ST_FIX) begin
         avg_ff <= avg_in;
      end
      if (out_load) begin
         rsp_volt_ff <= volt_ff;
         rsp_avg_ff  <= avg_ff;
         rsp_pct_ff  <= pct_in;
         rsp_drop_ff <= drop_in;
      end
   end

   // The reciprocal estimate must leave less than two divisors to correct.
   `BVM_ASSERT_NOW(a_scale_rem, clock, reset, state_ff == ST_CORR, scale_rem < ScaleRemMax,
      "scaling quotient estimate off by more than one")
   `BVM_ASSERT_NOW(a_avg_rem, clock, reset, state_ff == ST_FIX, avg_rem < (DepthV << 1),
      "average quotient estimate off by more than one")
   `BVM_ASSERT_NEXT(a_wptr_moves, clock, reset, state_ff == ST_UPD, wptr_ff != $past(wptr_ff),
      "write position did not advance on a ring update")
   `BVM_ASSERT_NOW(a_rsp_source, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_OUT,
      "response raised outside the output step")
   `BVM_ASSERT_NEXT(a_out_hold, clock, reset, (state_ff == ST_OUT) && !out_free,
      (state_ff == ST_OUT) && rsp_valid_ff, "stalled result left the output step")

endmodule

// File: bench/tb.sv
// Self-checking bench for the battery monitor: sample scaling, window average, charge and drop.
`timescale 1ns / 1ps

module tb import bvm_pkg::*; ();

   // The window depth the block is built with; the predictor keeps a ring of the same size.
   localparam int WindowDepth = 16;

   // The block scales a reading as raw * vref * 66 / 40950, which is twice 3.3 V over full scale.
   localparam longint unsigned ScaleNum = 66;
   localparam longint unsigned ScaleDen = 40950;

   // Width of the charge band in millivolts, between the empty and the full points.
   localparam int unsigned ChargeSpanMv = 1200;

   // Idle bounds of both sides, in cycles per request or response.
   localparam int MaxGap = 12;

   // Cycles we allow after the last response before a register write or the final verdict.
   // That leaves the block ample room to settle.
   localparam int SettleCycles = 10;

   // The watchdog fires when nothing at all is accepted for this many cycles.
   // The slowest legitimate quiet stretch is a sender gap plus the sequencer walk plus
   // a receiver stall plus a settle pause, well under this limit.
   localparam int QuietLimit = 2000;

   localparam int DirectedSixteen = 16;
   localparam int PhaseCount = 7;

   typedef struct packed {
      logic [VoltW-1:0] voltage_mv;
      logic [VoltW-1:0] average_mv;
      logic [PctW-1:0]  charge_percent;
      logic             drop_warning;
   } reading_type;

   // The scoreboard holds its own copy of the window and the reference register, works out
   // the reading that each accepted request must produce and checks responses in order.
   class battery_scoreboard;
      logic [VoltW-1:0] ring_mv[WindowDepth];
      int unsigned      slot;
      int unsigned      window_total;
      logic [VrefW-1:0] vref_mv;
      reading_type      expected_readings[$];
      int unsigned      mismatches;

      function new();
         foreach (ring_mv[i]) ring_mv[i] = '0;
         slot = 0;
         window_total = 0;
         vref_mv = VrefReset;
         mismatches = 0;
      endfunction

      function void set_vref(logic [VrefW-1:0] value);
         vref_mv = value;
      endfunction

      function int unsigned outstanding();
         return expected_readings.size();
      endfunction

      function void note_request(logic [RawW-1:0] raw);
         longint unsigned scaled;
         int unsigned     volt;
         int unsigned     avg;
         reading_type     want;
         scaled = (longint'(raw) * longint'(vref_mv) * ScaleNum) / ScaleDen;
         volt = (scaled > VoltMax) ? int'(VoltMax) : int'(scaled);
         window_total = window_total - ring_mv[slot] + volt;
         ring_mv[slot] = volt[VoltW-1:0];
         slot = (slot + 1) % WindowDepth;
         avg = window_total / WindowDepth;
         if (avg > VoltMax) avg = int'(VoltMax);
         want.voltage_mv = volt[VoltW-1:0];
         want.average_mv = avg[VoltW-1:0];
         if (avg >= FullMv)
            want.charge_percent = PctFull;
         else if (avg <= EmptyMv)
            want.charge_percent = PctNone;
         else
            want.charge_percent = PctW'(((avg - EmptyMv) * 100) / ChargeSpanMv);
         want.drop_warning = (10 * volt < 9 * avg);
         expected_readings.push_back(want);
      endfunction

      function void report(string what, int unsigned want, int unsigned got);
         if (mismatches < 10)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
         mismatches++;
      endfunction

      function void check_reading(reading_type got);
         reading_type want;
         if (expected_readings.size() == 0) begin
            if (mismatches < 10)
               $display("%0t: response arrived with no request outstanding", $time);
            mismatches++;
            return;
         end
         want = expected_readings.pop_front();
         if (got.voltage_mv !== want.voltage_mv)
            report("voltage_mv", want.voltage_mv, got.voltage_mv);
         if (got.average_mv !== want.average_mv)
            report("average_mv", want.average_mv, got.average_mv);
         if (got.charge_percent !== want.charge_percent)
            report("charge_percent", want.charge_percent, got.charge_percent);
         if (got.drop_warning !== want.drop_warning)
            report("drop_warning", want.drop_warning, got.drop_warning);
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [VrefW-1:0] csr_wr_data;

   bvm_req_if req_ch ();
   bvm_rsp_if rsp_ch ();

   battery_scoreboard monitor_sb = new();

   reading_type observed;
   int          quiet_cycles;
   bit          tx_burst;
   bit          rx_burst;
   int          rx_stall;
   int          rx_count;

   battery_voltage_monitor_top #(
      .WINDOW_DEPTH(WindowDepth)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // All handshakes are sampled at the rising edge, where the block and the drivers below
   // only ever change signals through nonblocking assignments, so the values seen here are
   // the ones that were stable just before the edge. A register write is mirrored into the
   // predictor at the very edge that the block takes it.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (csr_wr_en)
            monitor_sb.set_vref(csr_wr_data);
         if (req_ch.valid && req_ch.ready)
            monitor_sb.note_request(req_ch.raw_sample);
         if (rsp_ch.valid && rsp_ch.ready) begin
            observed.voltage_mv     = rsp_ch.voltage_mv;
            observed.average_mv     = rsp_ch.average_mv;
            observed.charge_percent = rsp_ch.charge_percent;
            observed.drop_warning   = rsp_ch.drop_warning;
            monitor_sb.check_reading(observed);
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_wr_en) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QuietLimit) begin
               $display("%0t: nothing accepted for %0d cycles", $time, QuietLimit);
               $display("Verification failed");
               $finish;
            end
         end
      end
   end

   // The response side stalls for a random number of cycles after each accepted response.
   // Every fifty responses it may switch to a burst stretch in which it never stalls. The
   // countdown runs whether or not a response is waiting, so stalls land on every phase of
   // the sequencer.
   initial begin
      rsp_ch.ready <= 1'b0;
      rx_stall = 0;
      rx_count = 0;
      rx_burst = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            rx_count++;
            if (rx_count % 50 == 0)
               rx_burst = ($urandom_range(0, 3) == 0);
            rx_stall = rx_burst ? 0 : $urandom_range(0, MaxGap);
         end
         if (rx_stall > 0) begin
            rsp_ch.ready <= 1'b0;
            rx_stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   function automatic int draw_gap();
      return tx_burst ? 0 : $urandom_range(0, MaxGap);
   endfunction

   // Offers one request after an idle gap and returns at the edge where it is taken. The
   // valid line is only lowered when there is a gap, so back-to-back requests keep it high.
   task automatic send_request(input logic [RawW-1:0] raw);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_ch.valid      <= 1'b0;
         req_ch.raw_sample <= RawW'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.raw_sample <= raw;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Holds the request side idle until every outstanding response has come back, then lets
   // the sequencer settle. One edge passes first so that a request taken at the edge this
   // task starts on has been noted by the scoreboard before the count is read.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (monitor_sb.outstanding() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Register writes only happen with the block drained and idle.
   task automatic write_vref(input logic [VrefW-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      csr_wr_data <= VrefW'($urandom);
   endtask

   // Most readings fall in the raw band that maps to roughly 2900..4300 mV at the current
   // reference, so the charge estimate moves through its whole slope. The rest are sharp dips
   // below that band to trip the drop flag, the full raw range, the extremes and tiny values.
   function automatic logic [RawW-1:0] pick_raw(input logic [VrefW-1:0] vref);
      int unsigned lo;
      int unsigned hi;
      int unsigned choice;
      choice = $urandom_range(0, 99);
      if (vref == 0)
         return RawW'($urandom);
      lo = 32'((2900 * ScaleDen) / (vref * ScaleNum));
      hi = 32'((4300 * ScaleDen) / (vref * ScaleNum));
      if (lo > 4095) lo = 4095;
      if (hi > 4095) hi = 4095;
      if (choice < 55)
         return RawW'($urandom_range(lo, hi));
      else if (choice < 70)
         return RawW'($urandom);
      else if (choice < 85)
         return RawW'($urandom_range(lo * 6 / 10, lo));
      else if (choice < 93)
         return ($urandom_range(0, 1) == 1) ? {RawW{1'b1}} : {RawW{1'b0}};
      else
         return RawW'($urandom_range(0, 15));
   endfunction

   initial begin
      logic [VrefW-1:0] phase_vref [PhaseCount];
      int               phase_len  [PhaseCount];
      logic [RawW-1:0]  raw;

      // The phases sweep the reference: both calibrated limits, the top of the field, where
      // the scaled voltage saturates, zero, and a few random calibrations of either kind.
      phase_vref = '{11'd1000, 11'd1200, {VrefW{1'b1}}, 11'd0,
                     VrefW'($urandom_range(1000, 1200)), VrefW'($urandom_range(1000, 1200)),
                     VrefW'($urandom)};
      phase_len  = '{100, 100, 100, 40, 100, 100, 100};

      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      req_ch.valid      <= 1'b0;
      req_ch.raw_sample <= '0;
      tx_burst = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset reference of 1100 mV. The first few requests land on an
      // all-zero window, so the warm-up average is diluted by empty entries. The field
      // extremes and alternating bit patterns come first.
      send_request('0);
      send_request({RawW{1'b1}});
      send_request(12'hAAA);
      send_request(12'h555);
      send_request(12'd1);
      // Sixteen readings just above the full point fill the window, wrap the write position
      // and push the average to the top of the charge range.
      for (int i = 0; i < DirectedSixteen; i++)
         send_request(12'd2370);
      // A sudden collapse against a full window raises the drop flag; the readings after it
      // walk the average back down through the linear part of the charge range.
      send_request('0);
      send_request(12'd1692);
      send_request(12'd2000);

      // Random part: every phase starts with a register write, which also makes the sender
      // wait for the block to empty completely. Within a phase the sender picks at random between
      // gapped stretches and bursts without gaps.
      for (int p = 0; p < PhaseCount; p++) begin
         write_vref(phase_vref[p]);
         for (int i = 0; i < phase_len[p]; i++) begin
            if (i % 25 == 0)
               tx_burst = ($urandom_range(0, 2) == 0);
            raw = pick_raw(phase_vref[p]);
            send_request(raw);
         end
      end

      drain();
      if (monitor_sb.mismatches == 0 && monitor_sb.outstanding() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+design
design/bvm_pkg.sv
design/bvm_if.sv
design/battery_voltage_monitor_top.sv
bench/tb.sv
